[src/pks_pkg.sv]
// ----------------------------------------------------------------------------
// pks_pkg: shared types and constants of the plucked string voice
// Request kinds, register indexes, widths, sequencer states and divider status.
// ----------------------------------------------------------------------------
package pks_pkg;

   typedef enum logic [1:0] {
      REQ_RESTART = 2'd0,
      REQ_WRITE   = 2'd1,
      REQ_ADVANCE = 2'd2,
      REQ_RELEASE = 2'd3
   } req_kind_type;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_LEN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOTE_MAX_LEN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_LEN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_LEN     = 3'd4;

   localparam int SAMPLE_W  = 16;
   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_W = 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_TAP,
      ST_RD_PREV,
      ST_LOOP_MUL,
      ST_WRITE,
      ST_TAP,
      ST_RD_OUT,
      ST_ENV,
      ST_ENV_MUL,
      ST_DIV_GO,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[src/plucked_string_voice.sv]
// ----------------------------------------------------------------------------
// plucked_string_voice: one Karplus-Strong string voice
// Ring store, loop filter with gain, linear attack/decay envelope.
//
//   channel | dir | handshake          | words
//   req     | in  | req_tvalid/tready  | restart, excitation write, advance, release
//   rsp     | out | rsp_tvalid/tready  | one enveloped sample per advance
//   csr     | in  | csr_wr_en          | five registers, no read-back
//
// Write and release are done in the idle state; restart then wraps the tap.
// Advance reads, multiplies, writes, wraps the tap and reads the output;
// in attack or decay it scales with the 16-step serial divider, and the
// wrap passes are up to ceil(delay_len / BUF_LEN), one adder pass each.
// Reset is synchronous and clears pointers, note count and registers; the
// ring store is not cleared. A stalled result holds the sequencer in its
// last state while the next request waits.
// ----------------------------------------------------------------------------
module plucked_string_voice #(
   parameter int BUF_LEN = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // write_index[9:0], excitation_value[25:10],
                                    // add_value[41:26], zero[47:42]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // sample_out[15:0]
   output logic        rsp_tuser,   // alive[0]
   input  logic        csr_wr_en,
   input  logic [pks_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pks_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(BUF_LEN);
   localparam int IW = ((AW > 10) ? AW : 10);
   localparam int TW = IW + 2;

   function automatic logic [15:0] sat16(input logic signed [17:0] v);
      logic [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // request fields
   pks_pkg::req_kind_type req_kind;
   logic [9:0]            req_write_index;
   logic [15:0]           req_excitation_value;
   logic [15:0]           req_add_value;

   assign req_kind             = pks_pkg::req_kind_type'(req_tuser);
   assign req_write_index      = req_tdata[9:0];
   assign req_excitation_value = req_tdata[25:10];
   assign req_add_value        = req_tdata[41:26];

   // registers
   logic [9:0]  delay_len_ff;
   logic [15:0] feedback_gain_ff;
   logic [23:0] note_max_len_ff;
   logic [15:0] attack_len_ff;
   logic [15:0] decay_len_ff;

   pks_pkg::state_type state_ff, state_in;

   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] rp_ff, rp_in;
   logic [23:0]   cnt_ff, cnt_in;
   logic          restart_ff, restart_in;
   logic [TW-1:0] tap_ff, tap_in;
   logic [15:0]   add_ff, add_in;
   logic [15:0]   d_ff, d_in;
   logic [34:0]   prod_ff, prod_in;
   logic [16:0]   mag_ff, mag_in;
   logic [15:0]   num_ff, num_in;
   logic [15:0]   den_ff, den_in;
   logic          neg_ff, neg_in;
   logic [15:0]   res_ff, res_in;
   logic          res_alive_ff, res_alive_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_data_ff, rsp_data_in;
   logic          rsp_alive_ff, rsp_alive_in;

   // ring and shared units
   logic          ring_we;
   logic [AW-1:0] ring_waddr;
   logic [15:0]   ring_wdata;
   logic [AW-1:0] ring_raddr;
   logic [15:0]   ring_rdata;

   logic                   div_start;
   pks_pkg::div_status_type div_status;
   logic [15:0]            div_quo;

   logic                mul_env_sel;
   logic signed [17:0]  mul_a;
   logic signed [16:0]  mul_b;
   logic signed [34:0]  mul_p;

   // derived values
   logic          req_accept;
   logic          rsp_free;
   logic          rsp_load;
   logic [AW-1:0] wp_next;
   logic [AW-1:0] wp_prev;
   logic [IW-1:0] idx_wide;
   logic          idx_ok;
   logic          dead;
   logic signed [24:0] rel_target;
   logic          rel_move;
   logic [23:0]   remain;
   logic          in_attack;
   logic          in_decay;
   logic [16:0]   sub_diff;
   logic [16:0]   loop_sum;
   logic [16:0]   s_wide;
   logic [15:0]   loop_y;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign wp_next    = (wp_ff == AW'(BUF_LEN - 1)) ? '0 : wp_ff + AW'(1);
   assign wp_prev    = (wp_ff == '0) ? AW'(BUF_LEN - 1) : wp_ff - AW'(1);
   assign idx_wide   = IW'(req_write_index);
   assign idx_ok     = 32'(req_write_index) < 32'(BUF_LEN);
   assign dead       = cnt_ff >= note_max_len_ff;
   assign rel_target = $signed({1'b0, note_max_len_ff}) - $signed({9'd0, decay_len_ff});
   assign rel_move   = $signed({1'b0, cnt_ff}) < rel_target;
   assign remain     = note_max_len_ff - cnt_ff;
   assign in_attack  = cnt_ff < {8'd0, attack_len_ff};
   assign in_decay   = remain < {8'd0, decay_len_ff};
   assign sub_diff   = {ring_rdata[15], ring_rdata} - {add_ff[15], add_ff};
   assign loop_sum   = {d_ff[15], d_ff} + {ring_rdata[15], ring_rdata};
   assign s_wide     = {ring_rdata[15], ring_rdata};
   assign loop_y     = sat16($signed(prod_ff[34:17]));

   // shared multiplier: loop gain, then envelope numerator
   assign mul_a = mul_env_sel ? $signed({1'b0, mag_ff}) : $signed({loop_sum[16], loop_sum});
   assign mul_b = mul_env_sel ? $signed({1'b0, num_ff}) : $signed({1'b0, feedback_gain_ff});
   assign mul_p = mul_a * mul_b;

   pks_ring #(
      .DEPTH (BUF_LEN),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   pks_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff[31:0]),
      .divisor  (den_ff),
      .status   (div_status),
      .quotient (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pks_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_kind)
                  pks_pkg::REQ_RESTART: state_in = pks_pkg::ST_TAP;
                  pks_pkg::REQ_ADVANCE: state_in = dead ? pks_pkg::ST_OUT : pks_pkg::ST_RD_TAP;
                  default:              state_in = pks_pkg::ST_IDLE;
               endcase
            end
         end
         pks_pkg::ST_RD_TAP:   state_in = pks_pkg::ST_RD_PREV;
         pks_pkg::ST_RD_PREV:  state_in = pks_pkg::ST_LOOP_MUL;
         pks_pkg::ST_LOOP_MUL: state_in = pks_pkg::ST_WRITE;
         pks_pkg::ST_WRITE:    state_in = pks_pkg::ST_TAP;
         pks_pkg::ST_TAP: begin
            if (!tap_ff[TW-1]) begin
               state_in = restart_ff ? pks_pkg::ST_IDLE : pks_pkg::ST_RD_OUT;
            end
         end
         pks_pkg::ST_RD_OUT:   state_in = pks_pkg::ST_ENV;
         pks_pkg::ST_ENV: begin
            state_in = (in_attack || in_decay) ? pks_pkg::ST_ENV_MUL : pks_pkg::ST_OUT;
         end
         pks_pkg::ST_ENV_MUL:  state_in = pks_pkg::ST_DIV_GO;
         pks_pkg::ST_DIV_GO:   state_in = pks_pkg::ST_DIV;
         pks_pkg::ST_DIV: begin
            if (div_status.done) begin
               state_in = pks_pkg::ST_OUT;
            end
         end
         pks_pkg::ST_OUT: begin
            if (rsp_free) begin
               state_in = pks_pkg::ST_IDLE;
            end
         end
         default: state_in = pks_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      ring_we     = 1'b0;
      ring_waddr  = wp_ff;
      ring_wdata  = loop_y;
      ring_raddr  = rp_ff;
      mul_env_sel = 1'b0;
      div_start   = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         pks_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && req_kind == pks_pkg::REQ_WRITE && idx_ok) begin
               ring_we    = 1'b1;
               ring_waddr = idx_wide[AW-1:0];
               ring_wdata = req_excitation_value;
            end
         end
         pks_pkg::ST_RD_PREV: ring_raddr  = wp_prev;
         pks_pkg::ST_WRITE:   ring_we     = 1'b1;
         pks_pkg::ST_ENV_MUL: mul_env_sel = 1'b1;
         pks_pkg::ST_DIV_GO:  div_start   = 1'b1;
         pks_pkg::ST_OUT:     rsp_load    = rsp_free;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      cnt_in       = cnt_ff;
      restart_in   = restart_ff;
      tap_in       = tap_ff;
      add_in       = add_ff;
      d_in         = d_ff;
      prod_in      = prod_ff;
      mag_in       = mag_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      res_alive_in = res_alive_ff;
      unique case (state_ff)
         pks_pkg::ST_IDLE: begin
            if (req_accept) begin
               add_in = req_add_value;
               unique case (req_kind)
                  pks_pkg::REQ_RESTART: begin
                     wp_in      = '0;
                     cnt_in     = '0;
                     restart_in = 1'b1;
                     tap_in     = TW'(0) - TW'(delay_len_ff);
                  end
                  pks_pkg::REQ_ADVANCE: begin
                     restart_in   = 1'b0;
                     res_in       = '0;
                     res_alive_in = 1'b0;
                  end
                  pks_pkg::REQ_RELEASE: begin
                     if (rel_move) begin
                        cnt_in = rel_target[23:0];
                     end
                  end
                  default: ;
               endcase
            end
         end
         pks_pkg::ST_RD_PREV:  d_in    = sat16($signed({sub_diff[16], sub_diff}));
         pks_pkg::ST_LOOP_MUL: prod_in = mul_p;
         pks_pkg::ST_WRITE: begin
            wp_in  = wp_next;
            cnt_in = cnt_ff + 24'd1;
            tap_in = TW'(wp_next) - TW'(delay_len_ff);
         end
         pks_pkg::ST_TAP: begin
            if (tap_ff[TW-1]) begin
               tap_in = tap_ff + TW'(BUF_LEN);
            end else begin
               rp_in = tap_ff[AW-1:0];
            end
         end
         pks_pkg::ST_ENV: begin
            neg_in       = ring_rdata[15];
            mag_in       = ring_rdata[15] ? (17'd0 - s_wide) : s_wide;
            num_in       = in_attack ? cnt_ff[15:0] : remain[15:0];
            den_in       = in_attack ? attack_len_ff : decay_len_ff;
            res_in       = ring_rdata;
            res_alive_in = 1'b1;
         end
         pks_pkg::ST_ENV_MUL: prod_in = mul_p;
         pks_pkg::ST_DIV: begin
            if (div_status.done) begin
               res_in = neg_ff ? (16'd0 - div_quo) : div_quo;
            end
         end
         default: ;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_alive_in = rsp_alive_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
         rsp_alive_in = res_alive_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= pks_pkg::ST_IDLE;
         wp_ff            <= '0;
         rp_ff            <= '0;
         cnt_ff           <= '0;
         restart_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         delay_len_ff     <= 10'd1;
         feedback_gain_ff <= '0;
         note_max_len_ff  <= '0;
         attack_len_ff    <= 16'd1;
         decay_len_ff     <= 16'd1;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cnt_ff       <= cnt_in;
         restart_ff   <= restart_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               pks_pkg::CSR_DELAY_LEN:     delay_len_ff     <= csr_wdata[9:0];
               pks_pkg::CSR_FEEDBACK_GAIN: feedback_gain_ff <= csr_wdata[15:0];
               pks_pkg::CSR_NOTE_MAX_LEN:  note_max_len_ff  <= csr_wdata;
               pks_pkg::CSR_ATTACK_LEN:    attack_len_ff    <= csr_wdata[15:0];
               pks_pkg::CSR_DECAY_LEN:     decay_len_ff     <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      tap_ff       <= tap_in;
      add_ff       <= add_in;
      d_ff         <= d_in;
      prod_ff      <= prod_in;
      mag_ff       <= mag_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      neg_ff       <= neg_in;
      res_ff       <= res_in;
      res_alive_ff <= res_alive_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_alive_ff <= rsp_alive_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_alive_ff;

endmodule

[src/pks_ring.sv]
// ----------------------------------------------------------------------------
// pks_ring: string delay memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pks_ring #(
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [pks_pkg::SAMPLE_W-1:0]  wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [pks_pkg::SAMPLE_W-1:0]  rd_data
);

   logic [pks_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic [pks_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/pks_div.sv]
// ----------------------------------------------------------------------------
// pks_div: serial restoring divider for the envelope
// Divides a 32-bit dividend by a 16-bit divisor, one quotient bit a cycle.
// The upper dividend half must be below the divisor (quotient fits 16 bits).
// ----------------------------------------------------------------------------
module pks_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [31:0]            dividend,
   input  logic [15:0]            divisor,
   output pks_pkg::div_status_type status,
   output logic [15:0]            quotient
);

   logic [15:0]                    rem_ff, rem_in;
   logic [15:0]                    quo_ff, quo_in;
   logic [15:0]                    dsr_ff, dsr_in;
   logic [pks_pkg::DIV_CNT_W-1:0]  step_ff, step_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [16:0]                    trial;
   logic [16:0]                    diff;
   logic                           ge;

   assign trial = {rem_ff, quo_ff[15]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[31:16];
         quo_in  = dividend[15:0];
         dsr_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[15:0] : trial[15:0];
         quo_in  = {quo_ff[14:0], ge};
         step_in = step_ff + pks_pkg::DIV_CNT_W'(1);
         if (step_ff == pks_pkg::DIV_CNT_W'(pks_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

[src/pks_checker.sv]
// ----------------------------------------------------------------------------
// pks_checker: port-level checks of the plucked string voice
// Watches the request and result channels; attached to the top by bind.
// ----------------------------------------------------------------------------
module pks_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word present after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   a_dead_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 16'd0)
      else $error("dead note gave a nonzero sample");

   a_busy_after_step : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready &&
         (req_tuser == pks_pkg::REQ_ADVANCE || req_tuser == pks_pkg::REQ_RESTART)
         |=> !req_tready)
      else $error("sequencer took a word while stepping");

endmodule

bind plucked_string_voice pks_checker u_pks_checker (.*);

[test/pks_voice_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pks_voice_checker: result prediction and compare for the plucked string voice
// Watches the request, result and register ports, keeps its own copy of the
// string state and checks every result word against the oldest prediction.
// ----------------------------------------------------------------------------
module pks_voice_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // write_index[9:0], excitation_value[25:10],
                                    // add_value[41:26], zero[47:42]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // sample_out[15:0]
   input  logic        rsp_tuser,   // alive[0]
   input  logic        csr_wr_en,
   input  logic [pks_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pks_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   import pks_pkg::*;

   localparam int RING_DEPTH = 1024;

   typedef struct packed {
      logic [15:0] sample;
      logic        alive;
   } voice_sample_t;

   logic signed [15:0] ring_copy [0:RING_DEPTH-1];
   logic [9:0]         wr_ptr;
   logic [9:0]         rd_ptr;
   logic [23:0]        note_cnt;

   logic [9:0]         cfg_delay;
   logic [15:0]        cfg_gain;
   logic [23:0]        cfg_max_len;
   logic [15:0]        cfg_attack;
   logic [15:0]        cfg_decay;

   voice_sample_t      expected_samples [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic logic signed [15:0] clip16(input longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   // envelope scaling, truncated toward zero
   function automatic logic [15:0] envelope_scale(input logic signed [15:0] s,
                                                  input longint num, input longint den);
      longint mag;
      longint q;
      mag = s;
      if (mag < 0) mag = -mag;
      q = (mag * num) / den;
      if (s < 0) q = -q;
      return q[15:0];
   endfunction

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   task automatic advance_string(input logic signed [15:0] add);
      voice_sample_t      res;
      logic [9:0]         prev_ptr;
      longint             loop_sum;
      longint             gain_l;
      longint             add_l;
      logic signed [15:0] tap;
      logic [23:0]        remain;
      if (note_cnt >= cfg_max_len) begin
         res.sample = '0;
         res.alive  = 1'b0;
      end else begin
         prev_ptr = wr_ptr - 10'd1;
         add_l    = add;
         loop_sum = ring_copy[rd_ptr];
         loop_sum = clip16(loop_sum - add_l);
         loop_sum = loop_sum + ring_copy[prev_ptr];
         gain_l   = cfg_gain;
         loop_sum = loop_sum * gain_l;
         ring_copy[wr_ptr] = clip16(loop_sum >>> 17);
         wr_ptr   = wr_ptr + 10'd1;
         rd_ptr   = wr_ptr - cfg_delay;
         note_cnt = note_cnt + 24'd1;
         tap      = ring_copy[rd_ptr];
         remain   = cfg_max_len - note_cnt;
         if (note_cnt < cfg_attack)
            tap = envelope_scale(tap, note_cnt, cfg_attack);
         else if (remain < cfg_decay)
            tap = envelope_scale(tap, remain, cfg_decay);
         res.sample = tap;
         res.alive  = 1'b1;
      end
      expected_samples.push_back(res);
   endtask

   task automatic apply_word(input req_kind_type kind, input logic [9:0] idx,
                             input logic signed [15:0] exc, input logic signed [15:0] add);
      int target;
      int count_i;
      case (kind)
         REQ_RESTART: begin
            wr_ptr   = '0;
            rd_ptr   = 10'd0 - cfg_delay;
            note_cnt = '0;
         end
         REQ_WRITE: begin
            ring_copy[idx] = exc;
         end
         REQ_RELEASE: begin
            target  = cfg_max_len;
            count_i = cfg_decay;
            target  = target - count_i;
            count_i = note_cnt;
            if (count_i < target) note_cnt = target[23:0];
         end
         default: begin
            advance_string(add);
         end
      endcase
   endtask

   always @(posedge clock) begin : watch_ports
      voice_sample_t want;
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) ring_copy[i] = '0;
         wr_ptr      = '0;
         rd_ptr      = '0;
         note_cnt    = '0;
         cfg_delay   = 10'd1;
         cfg_gain    = '0;
         cfg_max_len = '0;
         cfg_attack  = 16'd1;
         cfg_decay   = 16'd1;
         expected_samples.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               report_failure($sformatf("unexpected result word: sample %0d alive %0b",
                                        $signed(rsp_tdata), rsp_tuser));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata !== want.sample)
                  report_failure($sformatf("sample_out mismatch: expected %0d got %0d",
                                           $signed(want.sample), $signed(rsp_tdata)));
               if (rsp_tuser !== want.alive)
                  report_failure($sformatf("alive mismatch: expected %0b got %0b",
                                           want.alive, rsp_tuser));
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DELAY_LEN:     cfg_delay   = csr_wdata[9:0];
               CSR_FEEDBACK_GAIN: cfg_gain    = csr_wdata[15:0];
               CSR_NOTE_MAX_LEN:  cfg_max_len = csr_wdata[23:0];
               CSR_ATTACK_LEN:    cfg_attack  = csr_wdata[15:0];
               CSR_DECAY_LEN:     cfg_decay   = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            apply_word(req_kind_type'(req_tuser), req_tdata[9:0],
                       req_tdata[25:10], req_tdata[41:26]);
      end
      pending_count = expected_samples.size();
   end

endmodule

[test/tb_plucked_string_voice.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_plucked_string_voice: testbench of the plucked string voice
// Fills the ring with excitation, plays notes of advances, releases and
// restarts under many register settings with random stalls on both channels;
// the checker predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module tb_plucked_string_voice;
   import pks_pkg::*;

   localparam int WORD_TARGET   = 1350;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RING_DEPTH    = 1024;

   typedef struct packed {
      logic [9:0]  delay;
      logic [15:0] gain;
      logic [23:0] max_len;
      logic [15:0] attack;
      logic [15:0] decay;
   } voice_setting_t;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // write_index[9:0], excitation_value[25:10],
                             // add_value[41:26], zero[47:42]
   logic [1:0]  req_tuser;   // req_type[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // sample_out[15:0]
   logic        rsp_tuser;   // alive[0]
   logic        csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int   fail_count;
   int   pending;
   int   voice_words;
   int   fill_words;
   int   quiet_cycles;
   int   stall_left;
   logic idle_on;
   logic written_map [0:RING_DEPTH-1];

   always #5 clock = ~clock;

   plucked_string_voice i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pks_voice_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending)
   );

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   function automatic logic [15:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic voice_setting_t make_setting(input logic [9:0] d, input logic [15:0] g,
                                                   input logic [23:0] m, input logic [15:0] a,
                                                   input logic [15:0] dc);
      voice_setting_t s;
      s.delay   = d;
      s.gain    = g;
      s.max_len = m;
      s.attack  = a;
      s.decay   = dc;
      return s;
   endfunction

   function automatic voice_setting_t random_setting();
      voice_setting_t s;
      s.delay   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 40);
      s.gain    = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(40000, 65535);
      s.max_len = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 300);
      s.attack  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 40);
      s.decay   = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 40);
      return s;
   endfunction

   task automatic send_word(input req_kind_type kind, input logic [9:0] idx,
                            input logic [15:0] exc, input logic [15:0] add);
      if (idle_on && $urandom_range(0, 6) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, add, exc, idx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (kind == REQ_WRITE) written_map[idx] = 1'b1;
      voice_words++;
      if (voice_words - fill_words > WORD_TARGET - 200) idle_on = 1'b0;
   endtask

   // hold off until every expected word is back and the block has gone quiet
   task automatic settle_voice();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic apply_setting(input voice_setting_t s);
      settle_voice();
      write_register(CSR_DELAY_LEN, s.delay);
      write_register(CSR_FEEDBACK_GAIN, s.gain);
      write_register(CSR_NOTE_MAX_LEN, s.max_len);
      write_register(CSR_ATTACK_LEN, s.attack);
      write_register(CSR_DECAY_LEN, s.decay);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // excite every ring entry that the first steps after a restart can read
   task automatic fill_ring_tail(input logic [9:0] d);
      for (int i = RING_DEPTH - d; i < RING_DEPTH; i++) begin
         if (!written_map[i]) begin
            send_word(REQ_WRITE, 10'(i), random_sample(), $urandom);
            fill_words++;
         end
      end
   endtask

   task automatic play_note(input voice_setting_t s);
      int note_len;
      int pick;
      repeat ($urandom_range(0, 2))
         send_word(REQ_WRITE, $urandom_range(0, 1023), random_sample(), $urandom);
      send_word(REQ_RESTART, $urandom, $urandom, $urandom);
      note_len = (s.max_len <= 200) ? $urandom_range(4, s.max_len + 12) : $urandom_range(20, 90);
      repeat (note_len) begin
         pick = $urandom_range(0, 39);
         if (pick == 0)
            send_word(REQ_RELEASE, $urandom, $urandom, $urandom);
         else if (pick == 1)
            send_word(REQ_WRITE, $urandom_range(0, 1023), random_sample(), $urandom);
         else if (pick == 2)
            send_word(REQ_RESTART, $urandom, $urandom, $urandom);
         else
            send_word(REQ_ADVANCE, $urandom, $urandom, random_sample());
      end
   endtask

   task automatic run_phase(input voice_setting_t s, input int words);
      int start;
      apply_setting(s);
      fill_ring_tail(s.delay);
      start = voice_words - fill_words;
      while (voice_words - fill_words - start < words) play_note(s);
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = REQ_RESTART;
      rsp_tready   = 1'b1;
      csr_wr_en    = 1'b0;
      csr_index    = CSR_DELAY_LEN;
      csr_wdata    = '0;
      voice_words  = 0;
      fill_words   = 0;
      quiet_cycles = 0;
      stall_left   = 0;
      idle_on      = 1'b1;
      for (int i = 0; i < RING_DEPTH; i++) written_map[i] = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      apply_setting(make_setting(10'd1, 16'hFFFF, 24'd40, 16'd8, 16'd8));
      send_word(REQ_WRITE, 10'd1023, 16'h7FFF, 16'h0000);
      send_word(REQ_WRITE, 10'h155, 16'h5555, 16'hAAAA);
      send_word(REQ_WRITE, 10'h2AA, 16'hAAAA, 16'h5555);
      send_word(REQ_RESTART, 10'd0, 16'h0000, 16'h0000);
      send_word(REQ_ADVANCE, 10'd0, 16'h0000, 16'h8000);
      send_word(REQ_WRITE, 10'd1023, 16'h8000, 16'h0000);
      send_word(REQ_RESTART, 10'd0, 16'h0000, 16'h0000);
      send_word(REQ_ADVANCE, 10'd0, 16'h0000, 16'h7FFF);
      send_word(REQ_ADVANCE, 10'd0, 16'h0000, 16'h0000);
      send_word(REQ_RELEASE, 10'd0, 16'h0000, 16'h0000);
      repeat (10) send_word(REQ_ADVANCE, 10'd0, 16'h0000, 16'h0000);
      send_word(REQ_RELEASE, 10'd0, 16'h0000, 16'h0000);
      send_word(REQ_RESTART, 10'd0, 16'h0000, 16'h0000);
      repeat (2) send_word(REQ_ADVANCE, 10'd0, 16'h0000, random_sample());

      run_phase(make_setting(10'd1023, 16'h0000, 24'hFFFFFF, 16'hFFFF, 16'hFFFF), 100);
      run_phase(make_setting(10'd1023, 16'hFFFF, 24'd300, 16'd1, 16'd1), 100);
      run_phase(make_setting(10'd1, 16'hFFFF, 24'd0, 16'd1, 16'd1), 60);
      run_phase(make_setting(10'd2, 16'hFFFF, 24'hFFFFFF, 16'd1, 16'hFFFF), 100);
      while (voice_words - fill_words < WORD_TARGET) run_phase(random_setting(), 120);

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
